/* design/cte_pkg.sv */
package cte_pkg;

  localparam int unsigned YearW  = 8;
  localparam int unsigned MonW   = 4;
  localparam int unsigned MdayW  = 5;
  localparam int unsigned YdayW  = 9;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned LeapW  = 6;
  localparam int unsigned DaysW  = 17;
  localparam int unsigned HmsW   = 17;
  localparam int unsigned EpochW = 33;

  // year offsets from 1900
  localparam logic [YearW-1:0] EpochYear     = 8'd70;
  localparam logic [YearW-1:0] LeapsBefore   = 8'd17;   // multiples of 4 in 1..71
  localparam logic [YearW-1:0] SkipCentury   = 8'd200;  // 2100 is not leap
  localparam logic [YearW-1:0] PastSkip      = 8'd201;
  localparam logic [YearW-1:0] FirstCentury  = 8'd0;    // 1900 is not leap

  localparam logic [MonW-1:0]  LastMonth     = 4'd11;
  localparam logic [MonW-1:0]  MarchIdx      = 4'd2;

  localparam logic [DaysW-1:0] DaysPerYear   = 17'd365;
  localparam logic [HmsW-1:0]  SecsPerHour   = 17'd3600;
  localparam logic [HmsW-1:0]  SecsPerMin    = 17'd60;
  localparam logic [DaysW-1:0] SecsPerDay    = 17'd86400;

  typedef struct packed {
    logic [DaysW-1:0] days;
    logic [HmsW-1:0]  hms;
  } days_hms_t;

  function automatic logic [YdayW-1:0] days_before_month(input logic [MonW-1:0] mon);
    logic [YdayW-1:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    return d;
  endfunction

endpackage

/* design/cte_front.sv */
module cte_front import cte_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [YearW-1:0] years_since_1900_i,
  input  logic [MonW-1:0]  month_i,
  input  logic [MdayW-1:0] day_of_month_i,
  input  logic [YdayW-1:0] day_of_year_i,
  input  logic [HourW-1:0] hour_i,
  input  logic [MinW-1:0]  minute_i,
  input  logic [SecW-1:0]  second_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output days_hms_t        out_data_o
);

  logic             s1_valid_q, s1_valid_d;
  logic [DaysW-1:0] s1_year_days_q, s1_year_days_d;
  logic [YdayW-1:0] s1_yday_q, s1_yday_d;
  logic [HmsW-1:0]  s1_hms_q, s1_hms_d;
  logic             s1_ready;

  logic             s2_valid_q, s2_valid_d;
  days_hms_t        s2_data_q, s2_data_d;
  logic             s2_ready;

  logic             over_epoch;
  logic             leap;
  logic [YearW-1:0] nyears;
  logic [YearW-1:0] y_m1;
  logic [YearW-1:0] nleaps8;
  logic [LeapW-1:0] nleaps;
  logic [MonW-1:0]  mon_c;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // stage 1: whole-year days, day of year, time of day
  always_comb begin
    over_epoch = years_since_1900_i > EpochYear;
    nyears     = years_since_1900_i - EpochYear;
    y_m1       = years_since_1900_i - 8'd1;
    nleaps8    = {2'b00, y_m1[YearW-1:2]} - LeapsBefore
               - {7'b0, (years_since_1900_i >= PastSkip)};
    nleaps     = nleaps8[LeapW-1:0];
    leap       = (years_since_1900_i[1:0] == 2'b00) &&
                 (years_since_1900_i != FirstCentury) &&
                 (years_since_1900_i != SkipCentury);
    mon_c      = (month_i > LastMonth) ? LastMonth : month_i;

    if (over_epoch) begin
      s1_year_days_d = {9'b0, nyears} * DaysPerYear + {11'b0, nleaps};
    end else begin
      s1_year_days_d = '0;
    end

    if (day_of_month_i != '0) begin
      s1_yday_d = days_before_month(mon_c)
                + {8'b0, (leap && (mon_c >= MarchIdx))}
                + {4'b0, day_of_month_i} - 9'd1;
    end else begin
      s1_yday_d = day_of_year_i;
    end

    s1_hms_d = {12'b0, hour_i} * SecsPerHour
             + {11'b0, minute_i} * SecsPerMin
             + {11'b0, second_i};

    s1_valid_d = s1_ready ? in_valid_i : s1_valid_q;
  end

  // stage 2: total days
  always_comb begin
    s2_data_d.days = s1_year_days_q + {8'b0, s1_yday_q};
    s2_data_d.hms  = s1_hms_q;
    s2_valid_d     = s2_ready ? s1_valid_q : s2_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_year_days_q <= s1_year_days_d;
      s1_yday_q      <= s1_yday_d;
      s1_hms_q       <= s1_hms_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_data_q <= s2_data_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_data_q;

endmodule

/* design/cte_back.sv */
module cte_back import cte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  days_hms_t         in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [EpochW-1:0] epoch_seconds_o
);

  logic              s3_valid_q, s3_valid_d;
  logic [EpochW-1:0] s3_prod_q, s3_prod_d;
  logic [HmsW-1:0]   s3_hms_q;
  logic              s3_ready;

  logic              s4_valid_q, s4_valid_d;
  logic [EpochW-1:0] s4_epoch_q, s4_epoch_d;
  logic              s4_ready;

  assign s4_ready   = !s4_valid_q || out_ready_i;
  assign s3_ready   = !s3_valid_q || s4_ready;
  assign in_ready_o = s3_ready;

  always_comb begin
    s3_prod_d  = {16'b0, in_data_i.days} * {16'b0, SecsPerDay};
    s3_valid_d = s3_ready ? in_valid_i : s3_valid_q;
    s4_epoch_d = s3_prod_q + {16'b0, s3_hms_q};
    s4_valid_d = s4_ready ? s3_valid_q : s4_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s3_valid_d;
      s4_valid_q <= s4_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && in_valid_i) begin
      s3_prod_q <= s3_prod_d;
      s3_hms_q  <= in_data_i.hms;
    end
    if (s4_ready && s3_valid_q) begin
      s4_epoch_q <= s4_epoch_d;
    end
  end

  assign out_valid_o     = s4_valid_q;
  assign epoch_seconds_o = s4_epoch_q;

endmodule

/* design/calendar_to_epoch_seconds_top.sv */
// Broken-down GMT date/time to seconds since 1970-01-01 00:00:00.
//
// Input channel: in_valid_i / in_ready_o, one beat carries year (from 1900),
// month, day of month (0 = use day of year), day of year, hour, minute, second.
// Output channel: out_valid_o / out_ready_i, one beat carries epoch_seconds_o.
// Every input beat yields exactly one output beat, in order.
//
// Four register stages: year/day/time-of-day terms, day sum, multiply by
// 86400, final add. Throughput is one beat per cycle while the receiver
// keeps out_ready_i high.
//
// Each stage holds its own valid bit and advances when the stage after it is
// empty or moving, so a stalled receiver only freezes the occupied stages;
// empty stages still fill. in_ready_o drops only when all four stages hold
// data and out_ready_i is low.
//
// Reset (rst_ni low, asynchronous) empties the pipeline; no clearing pass.
module calendar_to_epoch_seconds_top import cte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [YearW-1:0]  years_since_1900_i,
  input  logic [MonW-1:0]   month_i,
  input  logic [MdayW-1:0]  day_of_month_i,
  input  logic [YdayW-1:0]  day_of_year_i,
  input  logic [HourW-1:0]  hour_i,
  input  logic [MinW-1:0]   minute_i,
  input  logic [SecW-1:0]   second_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [EpochW-1:0] epoch_seconds_o
);

  logic      mid_valid;
  logic      mid_ready;
  days_hms_t mid_data;

  cte_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .years_since_1900_i (years_since_1900_i),
    .month_i            (month_i),
    .day_of_month_i     (day_of_month_i),
    .day_of_year_i      (day_of_year_i),
    .hour_i             (hour_i),
    .minute_i           (minute_i),
    .second_i           (second_i),
    .out_valid_o        (mid_valid),
    .out_ready_i        (mid_ready),
    .out_data_o         (mid_data)
  );

  cte_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (mid_valid),
    .in_ready_o      (mid_ready),
    .in_data_i       (mid_data),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .epoch_seconds_o (epoch_seconds_o)
  );

  // input back-pressure only comes from a stalled receiver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output stall");

  // a stalled mid-pipeline beat is held intact
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_valid && !mid_ready) |=> (mid_valid && $stable(mid_data)))
    else $error("mid-pipeline beat lost or changed");

  // back half cannot stall while the receiver takes data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> mid_ready)
    else $error("back half stalled with receiver ready");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import cte_pkg::*;

  localparam int unsigned RandomBeats = 1950;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic [YearW-1:0] years;
    logic [MonW-1:0]  mon;
    logic [MdayW-1:0] mday;
    logic [YdayW-1:0] yday;
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  sec;
  } stamp_t;

  class epoch_scoreboard;
    logic [EpochW-1:0] expected_epochs [$];
    int errors = 0;

    function automatic longint unsigned leaps_through(longint unsigned n);
      return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic logic [EpochW-1:0] epoch_of(stamp_t s);
      longint unsigned month_start [12];
      longint unsigned yr, mon, yday, days, total;
      month_start = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
      yr = 1900 + s.years;
      days = 0;
      if (yr > 1970) begin
        days = (yr - 1970) * 365 + leaps_through(yr - 1) - leaps_through(1969);
      end
      if (s.mday != 0) begin
        mon = (s.mon > 11) ? 11 : s.mon;
        yday = month_start[mon];
        if (mon >= 2 && (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0))) begin
          yday++;
        end
        yday += s.mday - 1;
      end else begin
        yday = s.yday;
      end
      total = (days + yday) * 86400 + s.hour * 3600 + s.minute * 60 + s.sec;
      return total[EpochW-1:0];
    endfunction

    function void note_beat(stamp_t s);
      expected_epochs.push_back(epoch_of(s));
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [EpochW-1:0] got);
      logic [EpochW-1:0] want;
      if (expected_epochs.size() == 0) begin
        report($sformatf("epoch_seconds %0d with no beat outstanding", got));
      end else begin
        want = expected_epochs.pop_front();
        if (got !== want) begin
          report($sformatf("epoch_seconds got %0d, expected %0d", got, want));
        end
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [YearW-1:0]  years_since_1900_i = '0;
  logic [MonW-1:0]   month_i = '0;
  logic [MdayW-1:0]  day_of_month_i = '0;
  logic [YdayW-1:0]  day_of_year_i = '0;
  logic [HourW-1:0]  hour_i = '0;
  logic [MinW-1:0]   minute_i = '0;
  logic [SecW-1:0]   second_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [EpochW-1:0] epoch_seconds_o;

  epoch_scoreboard sb = new();
  bit              steady = 1'b0;
  int unsigned     cycles = 0;

  calendar_to_epoch_seconds_top uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .years_since_1900_i (years_since_1900_i),
    .month_i            (month_i),
    .day_of_month_i     (day_of_month_i),
    .day_of_year_i      (day_of_year_i),
    .hour_i             (hour_i),
    .minute_i           (minute_i),
    .second_i           (second_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .epoch_seconds_o    (epoch_seconds_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= steady ? 1'b1 : ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(epoch_seconds_o);
    end
  end

  function automatic stamp_t mk(int y, int mo, int md, int yd, int h, int mi, int s);
    stamp_t st;
    st.years  = YearW'(y);
    st.mon    = MonW'(mo);
    st.mday   = MdayW'(md);
    st.yday   = YdayW'(yd);
    st.hour   = HourW'(h);
    st.minute = MinW'(mi);
    st.sec    = SecW'(s);
    return st;
  endfunction

  function automatic stamp_t random_stamp();
    stamp_t st;
    int unsigned pick;
    if ($urandom_range(99) < 20) begin
      st = mk($urandom_range(255), $urandom_range(15), $urandom_range(31),
              $urandom_range(511), $urandom_range(31), $urandom_range(63),
              $urandom_range(63));
    end else begin
      st = mk($urandom_range(255), $urandom_range(11),
              ($urandom_range(99) < 20) ? 0 : $urandom_range(1, 31),
              $urandom_range(365), $urandom_range(23), $urandom_range(59),
              $urandom_range(60));
      pick = $urandom_range(9);
      if (pick == 0) st.years = YearW'($urandom_range(68, 72));
      else if (pick == 1) st.years = YearW'($urandom_range(99, 101));
      else if (pick == 2) st.years = YearW'($urandom_range(199, 201));
    end
    return st;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task drive_beat(stamp_t st);
    while (!steady && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    years_since_1900_i <= st.years;
    month_i            <= st.mon;
    day_of_month_i     <= st.mday;
    day_of_year_i      <= st.yday;
    hour_i             <= st.hour;
    minute_i           <= st.minute;
    second_i           <= st.sec;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beat(st);
    @(negedge clk_i);
  endtask

  initial begin
    while (cycles < CycleLimit) @(posedge clk_i);
    $display("FAIL calendar_to_epoch_seconds_top");
    $finish;
  end

  initial begin
    stamp_t directed [$];
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed.push_back(mk(0, 0, 1, 0, 0, 0, 0));
    directed.push_back(mk(69, 11, 31, 0, 23, 59, 59));
    directed.push_back(mk(70, 0, 1, 0, 0, 0, 0));
    directed.push_back(mk(70, 0, 0, 365, 23, 59, 60));
    directed.push_back(mk(71, 0, 1, 0, 0, 0, 0));
    directed.push_back(mk(72, 1, 29, 0, 12, 30, 30));
    directed.push_back(mk(72, 2, 1, 0, 0, 0, 0));
    directed.push_back(mk(100, 2, 1, 0, 0, 0, 0));
    directed.push_back(mk(100, 11, 31, 0, 23, 59, 59));
    directed.push_back(mk(200, 2, 1, 0, 0, 0, 0));
    directed.push_back(mk(201, 0, 1, 0, 0, 0, 0));
    directed.push_back(mk(255, 11, 31, 0, 23, 59, 60));
    directed.push_back(mk(255, 15, 31, 0, 31, 63, 63));
    directed.push_back(mk(124, 12, 5, 0, 6, 7, 8));
    directed.push_back(mk(124, 15, 1, 0, 0, 0, 0));
    directed.push_back(mk(99, 0, 0, 511, 31, 63, 63));
    directed.push_back(mk(255, 0, 0, 511, 31, 63, 63));
    directed.push_back(mk(130, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(68, 5, 15, 0, 10, 20, 30));
    directed.push_back(mk(73, 1, 31, 0, 1, 1, 1));
    directed.push_back(mk(0, 0, 0, 0, 0, 0, 0));
    foreach (directed[i]) drive_beat(directed[i]);

    for (int i = 0; i < RandomBeats; i++) begin
      steady = (i >= 700 && i < 1000);
      drive_beat(random_stamp());
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.expected_epochs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.errors == 0 && sb.expected_epochs.size() == 0) begin
      $display("PASS calendar_to_epoch_seconds_top");
    end else begin
      $display("FAIL calendar_to_epoch_seconds_top");
    end
    $finish;
  end

endmodule
